[design/afx_pkg.sv]
// Shared types and constants for the conditional ALU execute block.
package afx_pkg;

  localparam int DATA_W = 16;
  localparam int STEP_CNT_W = $clog2(DATA_W);
  localparam logic [DATA_W-1:0] SIGN_MASK = 16'h8000;
  localparam logic [DATA_W-1:0] SHIFT_MAX = 16'd16;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_SHL  = 4'd4,
    OP_SHR  = 4'd5,
    OP_AND  = 4'd6,
    OP_OR   = 4'd7,
    OP_NOT  = 4'd8,
    OP_CMP  = 4'd9,
    OP_TEST = 4'd10,
    OP_MOV  = 4'd11
  } op_t;

  typedef enum logic [1:0] {
    COND_EQ  = 2'd0,
    COND_NE  = 2'd1,
    COND_GT  = 2'd2,
    COND_ALW = 2'd3
  } cond_t;

  typedef struct packed {
    logic               o;
    logic               c;
    logic               n;
    logic               z;
  } flags_t;

  typedef struct packed {
    logic [3:0]         kind;
    logic [1:0]         cond;
    logic signed [15:0] dest_value;
    logic signed [15:0] source_value;
  } in_t;

  typedef struct packed {
    logic signed [15:0] result;
    logic               write_back;
    logic               executed;
    logic               divide_error;
    logic               flag_zero;
    logic               flag_negative;
    logic               flag_carry;
    logic               flag_overflow;
  } out_t;

  // ALU outcome handed back to the sequencer
  typedef struct packed {
    out_t               item;
    flags_t             flags;
    logic               run_ok;
  } alu_res_t;

endpackage

[design/afx_seq_unit.sv]
// Shared iterative unit: radix-2 unsigned divide and shift-add multiply, one adder.
module afx_seq_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       is_div,
  input  logic [afx_pkg::DATA_W-1:0] opa,
  input  logic [afx_pkg::DATA_W-1:0] opb,
  output logic                       busy,
  output logic [afx_pkg::DATA_W-1:0] res
);
  import afx_pkg::*;

  localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(DATA_W - 1);

  logic [DATA_W-1:0]     q;     // dividend/quotient or multiplier
  logic [DATA_W-1:0]     b;     // divisor or multiplicand
  logic [DATA_W-1:0]     rem;   // remainder or product accumulator
  logic [STEP_CNT_W-1:0] cnt;
  logic                  mode_div;
  logic [DATA_W+1:0]     add_a;
  logic [DATA_W+1:0]     add_b;
  logic                  cin;
  logic [DATA_W+1:0]     sum;
  logic                  ge;

  // single shared adder
  always_comb begin
    if (mode_div) begin
      add_a = {1'b0, rem, q[DATA_W-1]};
      add_b = ~{2'b00, b};
      cin   = 1'b1;
    end else begin
      add_a = {2'b00, rem};
      add_b = {2'b00, b};
      cin   = 1'b0;
    end
    sum = add_a + add_b + {{(DATA_W+1){1'b0}}, cin};
    ge  = ~sum[DATA_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      cnt      <= '0;
      mode_div <= is_div;
      q        <= opa;
      b        <= opb;
      rem      <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == LAST_STEP) busy <= 1'b0;
      if (mode_div) begin
        if (ge) begin
          rem <= sum[DATA_W-1:0];
          q   <= {q[DATA_W-2:0], 1'b1};
        end else begin
          rem <= {rem[DATA_W-2:0], q[DATA_W-1]};
          q   <= {q[DATA_W-2:0], 1'b0};
        end
      end else begin
        if (q[0]) rem <= sum[DATA_W-1:0];
        q <= {1'b0, q[DATA_W-1:1]};
        b <= {b[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign res = mode_div ? q : rem;

endmodule

[design/afx_alu.sv]
// Combinational operation results, condition check and flag update.
module afx_alu (
  input  afx_pkg::in_t               item,
  input  afx_pkg::flags_t            flags,
  input  logic [afx_pkg::DATA_W-1:0] iter_res,
  output afx_pkg::alu_res_t          res
);
  import afx_pkg::*;

  logic [DATA_W-1:0]        d;
  logic [DATA_W-1:0]        s;
  logic [DATA_W-1:0]        s_neg;
  logic [DATA_W-1:0]        r;
  logic [DATA_W:0]          add_sum;
  logic [DATA_W:0]          sub_sum;
  logic [4:0]               sh;
  logic [2*DATA_W-1:0]      shl_wide;
  logic signed [DATA_W:0]   shr_wide;
  logic                     cond_ok;
  logic                     run_ok;
  logic                     wb;
  logic                     ex;
  logic                     de;
  flags_t                   fn;

  assign d        = item.dest_value;
  assign s        = item.source_value;
  assign s_neg    = ~s + 16'd1;
  assign add_sum  = {1'b0, d} + {1'b0, s};
  assign sub_sum  = {1'b0, d} + {1'b0, s_neg};
  assign sh       = s[4:0];
  assign shl_wide = {{DATA_W{1'b0}}, d} << sh;
  assign shr_wide = $signed({d, 1'b0}) >>> sh;

  always_comb begin
    case (item.cond)
      COND_EQ: cond_ok = flags.z;
      COND_NE: cond_ok = ~flags.z;
      COND_GT: cond_ok = ~flags.z & ~flags.n;
      default: cond_ok = 1'b1;
    endcase
    run_ok = (item.kind <= OP_MOV) && cond_ok;
  end

  always_comb begin
    fn = flags;
    r  = d;
    wb = 1'b0;
    ex = 1'b0;
    de = 1'b0;
    if (run_ok) begin
      ex = 1'b1;
      wb = 1'b1;
      case (item.kind)
        OP_ADD: begin
          r    = add_sum[DATA_W-1:0];
          fn.c = add_sum[DATA_W];
          fn.o = (~(d[15] ^ s[15])) & (d[15] ^ r[15]);
          fn.z = (r == '0);
          fn.n = r[15];
        end
        OP_SUB, OP_CMP: begin
          fn.c = sub_sum[DATA_W];
          fn.o = (s == SIGN_MASK) |
                 ((~(d[15] ^ s_neg[15])) & (d[15] ^ sub_sum[15]));
          fn.z = (sub_sum[DATA_W-1:0] == '0);
          fn.n = sub_sum[15];
          if (item.kind == OP_SUB) r = sub_sum[DATA_W-1:0];
          else wb = 1'b0;
        end
        OP_MUL: begin
          r    = iter_res;
          fn.z = (r == '0);
          fn.n = r[15];
        end
        OP_DIV: begin
          if (s == '0) begin
            de = 1'b1;
            wb = 1'b0;
          end else begin
            r    = (d[15] ^ s[15]) ? (~iter_res + 16'd1) : iter_res;
            fn.z = (r == '0);
            fn.n = r[15];
          end
        end
        OP_SHL: begin
          if (s == '0) begin
            fn.c = 1'b0;
          end else if (s > SHIFT_MAX) begin
            r    = '0;
            fn.c = 1'b0;
          end else begin
            r    = shl_wide[DATA_W-1:0];
            fn.c = shl_wide[DATA_W];
          end
        end
        OP_SHR: begin
          if (s == '0) begin
            fn.c = 1'b0;
          end else if (s > SHIFT_MAX) begin
            r    = {DATA_W{d[15]}};
            fn.c = d[15];
          end else begin
            r    = shr_wide[DATA_W:1];
            fn.c = shr_wide[0];
          end
        end
        OP_AND: begin
          r    = d & s;
          fn.z = (r == '0);
          fn.n = r[15];
        end
        OP_OR: begin
          r    = d | s;
          fn.z = (r == '0);
          fn.n = r[15];
        end
        OP_NOT: begin
          r    = ~d;
          fn.z = (r == '0);
          fn.n = r[15];
        end
        OP_TEST: begin
          fn.z = ((d & s) == '0);
          fn.n = d[15] & s[15];
          wb   = 1'b0;
        end
        default: begin // mov
          r    = s;
          fn.z = (r == '0);
          fn.n = r[15];
        end
      endcase
    end
  end

  always_comb begin
    res.run_ok              = run_ok;
    res.flags               = fn;
    res.item.result         = r;
    res.item.write_back     = wb;
    res.item.executed       = ex;
    res.item.divide_error   = de;
    res.item.flag_zero      = fn.z;
    res.item.flag_negative  = fn.n;
    res.item.flag_carry     = fn.c;
    res.item.flag_overflow  = fn.o;
  end

endmodule

[design/alu_execute_with_flags_top.sv]
// Top level of the conditional 16-bit ALU execute block with status flags.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one operation: kind,
//   condition, destination and source operands. A transfer happens on a rising
//   edge with in_valid high and in_stall low.
//   Output channel (out_valid / out_stall / out_data) returns exactly one
//   result per input: new destination value, write-back / executed /
//   divide-error bits and the Z, N, C, O flags after the step.
//   Timing: one item at a time. Multiply and divide run 16 steps through the
//   shared shift-add / restoring-divide unit, passing through the calculate,
//   iterate and write states before their result is loaded into the output
//   register. All other operations, and mul/div whose condition
//   fails or whose divisor is zero, go from the calculate state straight to
//   the write state. The next item can transfer after the result load.
//   The status flags live here; they are updated when a result is loaded into
//   the output register, so the next item's condition sees them.
//   A stalled output holds its result; the block finishes the current item and
//   waits before loading, so in_stall stays high until the slot frees.
//   Reset (rst, synchronous) clears the flags, the output valid and the
//   sequencer; no result is in flight afterwards.
module alu_execute_with_flags_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  afx_pkg::in_t    in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output afx_pkg::out_t   out_data
);
  import afx_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_ITER,
    ST_WRITE
  } state_t;

  state_t            state;
  in_t               item;      // captured operation
  flags_t            flags;     // kept status flags
  alu_res_t          alu_res;
  logic              need_iter;
  logic              unit_start;
  logic              unit_is_div;
  logic              unit_busy;
  logic [DATA_W-1:0] unit_res;
  logic [DATA_W-1:0] abs_d;
  logic [DATA_W-1:0] abs_s;
  logic [DATA_W-1:0] unit_opa;
  logic [DATA_W-1:0] unit_opb;
  logic              load_out;

  afx_alu u_alu (
    .item     (item),
    .flags    (flags),
    .iter_res (unit_res),
    .res      (alu_res)
  );

  // Divide works on magnitudes; sign is fixed up in the ALU.
  assign abs_d = item.dest_value[15]   ? (~item.dest_value + 16'd1)   : item.dest_value;
  assign abs_s = item.source_value[15] ? (~item.source_value + 16'd1) : item.source_value;

  assign unit_is_div = (item.kind == OP_DIV);
  assign need_iter   = alu_res.run_ok &&
                       ((item.kind == OP_MUL) ||
                        ((item.kind == OP_DIV) && (item.source_value != '0)));
  assign unit_start  = (state == ST_CALC) && need_iter;
  assign unit_opa    = unit_is_div ? abs_d : item.source_value;
  assign unit_opb    = unit_is_div ? abs_s : item.dest_value;

  afx_seq_unit u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (unit_start),
    .is_div (unit_is_div),
    .opa    (unit_opa),
    .opb    (unit_opb),
    .busy   (unit_busy),
    .res    (unit_res)
  );

  assign in_stall = (state != ST_IDLE);
  assign load_out = (state == ST_WRITE) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      flags     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !load_out) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            item  <= in_data;
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          state <= need_iter ? ST_ITER : ST_WRITE;
        end
        ST_ITER: begin
          if (!unit_busy) state <= ST_WRITE;
        end
        ST_WRITE: begin
          if (load_out) begin
            out_data  <= alu_res.item;
            out_valid <= 1'b1;
            flags     <= alu_res.flags;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Flags move only when a result is loaded.
  a_flags_hold: assert property (@(posedge clk) disable iff (rst)
    !load_out |=> $stable(flags))
    else $error("status flags changed without a result load");

  // The shared unit runs only while the sequencer waits on it.
  a_unit_owned: assert property (@(posedge clk) disable iff (rst)
    unit_busy |-> (state == ST_ITER))
    else $error("iterative unit busy outside the iterate state");

  // A divide error never writes back and always counts as executed.
  a_div_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.divide_error |-> !out_data.write_back && out_data.executed)
    else $error("divide error with write-back or without execution");

  // Nothing is written back when the operation did not run.
  a_no_run_no_wb: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.executed |-> !out_data.write_back)
    else $error("write-back on an operation that did not run");

  // A result load presents an output and returns to idle, where a new item is taken.
  a_load_after_write: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid && (state == ST_IDLE))
    else $error("result load did not present an output");

endmodule
